// ----- design/bmhq_pkg.sv -----
package bmhq_pkg;

  // Heap geometry
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child index 2*i+2 can reach 2*CAPACITY
  localparam int CHILD_W  = ADDR_W + 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((KEY_BITS + ADDR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_BITS + CNT_W + 7) / 8) * 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [CHILD_W-1:0]         child_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT      = 2'd0,
    OP_EXTRACT_MAX = 2'd1,
    OP_EXTRACT_AT  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_X_RDT,
    S_X_RDL,
    S_X_GOTL,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_LR,
    S_DN_CUR,
    S_PUT,
    S_DONE
  } state_e;

  // Operand selection of the shared comparator
  typedef enum logic [1:0] {
    CMP_UP,   // moving key vs parent
    CMP_LR,   // right child vs left child
    CMP_CUR   // larger child vs moving key
  } cmp_sel_e;

  // Heap store access for one cycle
  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    key_t    value;
    status_e status;
    cnt_t    occupancy;
  } result_t;

endpackage

// ----- design/bmhq_ram.sv -----
module bmhq_ram
  import bmhq_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output key_t     rdata_o
);

  key_t mem_q [CAPACITY];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

// ----- design/bmhq_cmp.sv -----
module bmhq_cmp
  import bmhq_pkg::*;
(
  input  cmp_sel_e sel_i,
  input  key_t     rdata_i,
  input  key_t     cand_i,
  input  key_t     cur_i,
  output logic     gt_o
);

  key_t op_a;
  key_t op_b;

  // Operand mux in front of the single signed compare
  always_comb begin
    case (sel_i)
      CMP_UP: begin
        op_a = cur_i;
        op_b = rdata_i;
      end
      CMP_LR: begin
        op_a = rdata_i;
        op_b = cand_i;
      end
      CMP_CUR: begin
        op_a = cand_i;
        op_b = cur_i;
      end
      default: begin
        op_a = cur_i;
        op_b = rdata_i;
      end
    endcase
  end

  // Strictly greater; ties keep the entry in place
  assign gt_o = op_a > op_b;

endmodule

// ----- design/bmhq_seq.sv -----
module bmhq_seq
  import bmhq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [OP_W-1:0] op_i,
  input  key_t          key_i,
  input  addr_t         pos_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output result_t       res_o,
  output mem_req_t      mem_req_o,
  input  key_t          rdata_i
);

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  addr_t   idx_q, idx_d;
  key_t    cur_q, cur_d;
  key_t    cand_q, cand_d;
  addr_t   cand_idx_q, cand_idx_d;
  logic    first_q, first_d;
  key_t    value_q, value_d;
  status_e status_q, status_d;

  cmp_sel_e cmp_sel;
  logic     cmp_gt;
  addr_t    parent_idx;
  child_t   child_l;
  child_t   child_r;
  child_t   cnt_ext;

  // Index arithmetic around the hole
  assign parent_idx = (idx_q - addr_t'(1)) >> 1;
  assign child_l    = {1'b0, idx_q, 1'b1};
  assign child_r    = child_l + child_t'(1);
  assign cnt_ext    = child_t'(cnt_q);

  bmhq_cmp u_cmp (
    .sel_i   (cmp_sel),
    .rdata_i (rdata_i),
    .cand_i  (cand_q),
    .cur_i   (cur_q),
    .gt_o    (cmp_gt)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    cand_q     <= cand_d;
    cand_idx_q <= cand_idx_d;
    value_q    <= value_d;
    status_q   <= status_d;
  end

  // Sequencer: the moving key stays in cur_q, entries shift through the hole
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    cand_d      = cand_q;
    cand_idx_d  = cand_idx_q;
    first_d     = first_q;
    value_d     = value_q;
    status_d    = status_q;
    mem_req_o   = '0;
    cmp_sel     = CMP_UP;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          value_d  = '0;
          status_d = ST_OK;
          first_d  = 1'b0;
          case (op_e'(op_i))
            OP_INSERT: begin
              if (cnt_q == cnt_t'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                cur_d   = key_i;
                idx_d   = addr_t'(cnt_q);
                cnt_d   = cnt_q + cnt_t'(1);
                state_d = (cnt_q == '0) ? S_PUT : S_UP_RD;
              end
            end
            OP_EXTRACT_MAX: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                idx_d   = '0;
                cnt_d   = cnt_q - cnt_t'(1);
                state_d = S_X_RDT;
              end
            end
            OP_EXTRACT_AT: begin
              if (cnt_t'(pos_i) >= cnt_q) begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end else begin
                idx_d   = pos_i;
                cnt_d   = cnt_q - cnt_t'(1);
                state_d = S_X_RDT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // fetch the entry being removed
      S_X_RDT: begin
        mem_req_o.raddr = idx_q;
        state_d         = S_X_RDL;
      end

      // capture it, then fetch the last entry unless the removed one was last
      S_X_RDL: begin
        value_d = rdata_i;
        if (cnt_t'(idx_q) == cnt_q) begin
          state_d = S_DONE;
        end else begin
          mem_req_o.raddr = addr_t'(cnt_q);
          state_d         = S_X_GOTL;
        end
      end

      S_X_GOTL: begin
        cur_d = rdata_i;
        if (idx_q == '0) begin
          state_d = S_DN_RDL;
        end else begin
          first_d = 1'b1;
          state_d = S_UP_RD;
        end
      end

      S_UP_RD: begin
        mem_req_o.raddr = parent_idx;
        state_d         = S_UP_CMP;
      end

      // parent moves down into the hole while the key beats it
      S_UP_CMP: begin
        cmp_sel = CMP_UP;
        if (cmp_gt) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = idx_q;
          mem_req_o.wdata = rdata_i;
          idx_d           = parent_idx;
          first_d         = 1'b0;
          state_d         = (parent_idx == '0) ? S_PUT : S_UP_RD;
        end else if (first_q) begin
          first_d = 1'b0;
          state_d = S_DN_RDL;
        end else begin
          state_d = S_PUT;
        end
      end

      S_DN_RDL: begin
        if (child_l >= cnt_ext) begin
          state_d = S_PUT;
        end else begin
          mem_req_o.raddr = addr_t'(child_l);
          state_d         = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        cand_d     = rdata_i;
        cand_idx_d = addr_t'(child_l);
        if (child_r < cnt_ext) begin
          mem_req_o.raddr = addr_t'(child_r);
          state_d         = S_DN_LR;
        end else begin
          state_d = S_DN_CUR;
        end
      end

      // right child wins only when strictly larger
      S_DN_LR: begin
        cmp_sel = CMP_LR;
        if (cmp_gt) begin
          cand_d     = rdata_i;
          cand_idx_d = addr_t'(child_r);
        end
        state_d = S_DN_CUR;
      end

      // larger child moves up into the hole
      S_DN_CUR: begin
        cmp_sel = CMP_CUR;
        if (cmp_gt) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = idx_q;
          mem_req_o.wdata = cand_q;
          idx_d           = cand_idx_q;
          state_d         = S_DN_RDL;
        end else begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = cur_q;
        state_d         = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = '{value: value_q, status: status_q, occupancy: cnt_q};

endmodule

// ----- design/binary_max_heap_queue_top.sv -----
// Binary max-heap priority queue, one result per request.
// An error or an unused op goes straight to the result. An insert climbs level by level
// (parent read, then compare). An extract fetches the removed and last entries, then moves
// down level by level (left read, right read, child compare, key compare) or climbs.
// One request at a time: a new input transfer can come from the cycle after the result
// enters the output register. Reset (rst_ni low, async) empties the queue, not the store.
module binary_max_heap_queue_top
  import bmhq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // key, position
  input  logic [OP_W-1:0]       s_axis_tuser_i,  // op
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // value, occupancy
  output logic [STATUS_W-1:0]   m_axis_tuser_o   // status
);

  mem_req_t mem_req;
  key_t     rdata;
  key_t     in_key;
  addr_t    in_pos;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [STATUS_W-1:0]   m_user_q;

  assign in_key = s_axis_tdata_i[KEY_BITS-1:0];
  assign in_pos = s_axis_tdata_i[KEY_BITS +: ADDR_W];

  bmhq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bmhq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .key_i       (in_key),
    .pos_i       (in_pos),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata)
  );

  // Output register: loads whenever it is empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= OUT_DATA_W'({res.occupancy, res.value});
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTH
  // occupancy never exceeds the store
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[KEY_BITS +: CNT_W] <= cnt_t'(CAPACITY))
    else $error("occupancy above capacity");

  // a dropped insert only happens on a full queue
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_FULL
    |-> m_axis_tdata_o[KEY_BITS +: CNT_W] == cnt_t'(CAPACITY)
        && m_axis_tdata_o[KEY_BITS-1:0] == '0)
    else $error("full status with free space or nonzero value");

  // empty status reports an empty queue and no value
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_EMPTY
    |-> m_axis_tdata_o[KEY_BITS +: CNT_W] == '0 && m_axis_tdata_o[KEY_BITS-1:0] == '0)
    else $error("empty status with entries or nonzero value");

  // the sequencer takes one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");
`endif

endmodule

// ----- tb/binary_max_heap_queue_checker.sv -----
`timescale 1ns / 1ps

// Watches both stream channels of the heap queue, keeps its own copy of the
// heap and compares every result transfer with the oldest predicted one.
module binary_max_heap_queue_checker
  import bmhq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // key, position
  input  logic [OP_W-1:0]       s_axis_tuser_i,  // op
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,  // value, occupancy
  input  logic [STATUS_W-1:0]   m_axis_tuser_i,  // status
  output int                    mismatch_count_o,
  output int                    pending_o
);

  // Shadow heap
  key_t    heap_keys [CAPACITY];
  int      heap_count;
  result_t expected_q [$];
  int      mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t heap checker: %s", $time, msg);
  endtask

  function automatic void swap_keys(int a, int b);
    key_t t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Move an entry toward the root while it beats its parent
  function automatic void sift_up(int start);
    int i;
    int parent;
    i = start;
    while (i > 0) begin
      parent = (i - 1) / 2;
      if (!(heap_keys[i] > heap_keys[parent])) break;
      swap_keys(i, parent);
      i = parent;
    end
  endfunction

  // Move an entry toward the leaves; left child wins ties
  function automatic void sift_down(int start);
    int i;
    int l;
    int best;
    i = start;
    while (i < heap_count) begin
      l = 2 * i + 1;
      if (l >= heap_count) break;
      best = i;
      if (heap_keys[l] > heap_keys[best]) best = l;
      if (l + 1 < heap_count && heap_keys[l + 1] > heap_keys[best]) best = l + 1;
      if (best == i) break;
      swap_keys(i, best);
      i = best;
    end
  endfunction

  // Apply one request to the shadow heap and return the result it should give
  function automatic result_t serve_request(logic [OP_W-1:0] op, key_t key, addr_t pos);
    result_t res;
    int      slot;
    res.value  = '0;
    res.status = ST_OK;
    slot       = int'(pos);
    case (op)
      OP_INSERT: begin
        if (heap_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          heap_keys[heap_count] = key;
          heap_count++;
          sift_up(heap_count - 1);
        end
      end
      OP_EXTRACT_MAX: begin
        if (heap_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = heap_keys[0];
          heap_count--;
          heap_keys[0] = heap_keys[heap_count];
          sift_down(0);
        end
      end
      OP_EXTRACT_AT: begin
        if (slot >= heap_count) begin
          res.status = ST_RANGE;
        end else begin
          res.value = heap_keys[slot];
          heap_count--;
          // the last entry fills the hole and goes whichever way it must
          if (slot != heap_count) begin
            heap_keys[slot] = heap_keys[heap_count];
            if (slot > 0 && heap_keys[slot] > heap_keys[(slot - 1) / 2]) sift_up(slot);
            else sift_down(slot);
          end
        end
      end
      default: ;  // unused op: no change, plain result
    endcase
    res.occupancy = cnt_t'(heap_count);
    return res;
  endfunction

  task automatic check_result(input logic [OUT_DATA_W-1:0] data,
                              input logic [STATUS_W-1:0] stat);
    result_t want;
    key_t    got_value;
    cnt_t    got_occ;
    got_value = data[KEY_BITS-1:0];
    got_occ   = data[KEY_BITS +: CNT_W];
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with none pending: value=%0d status=%0d occ=%0d",
                                got_value, stat, got_occ));
      return;
    end
    want = expected_q.pop_front();
    if (got_value !== want.value)
      report_mismatch($sformatf("value %0d, predicted %0d", got_value, want.value));
    if (stat !== want.status)
      report_mismatch($sformatf("status %0d, predicted %0d", stat, want.status));
    if (got_occ !== want.occupancy)
      report_mismatch($sformatf("occupancy %0d, predicted %0d", got_occ, want.occupancy));
  endtask

  // Results are checked before the same edge's request is applied
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_count = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i, m_axis_tuser_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_q.push_back(serve_request(s_axis_tuser_i,
                                           s_axis_tdata_i[KEY_BITS-1:0],
                                           s_axis_tdata_i[KEY_BITS +: ADDR_W]));
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/binary_max_heap_queue_top_tb.sv -----
`timescale 1ns / 1ps

module binary_max_heap_queue_top_tb
  import bmhq_pkg::*;
;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int REQUEST_TOTAL = 1900;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_e;

  logic                  clk    = 1'b0;
  logic                  rst_n  = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [OP_W-1:0]       s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  int                    fail_count;
  int                    pending_count;

  // Stimulus-side occupancy, used only to aim positions at live entries
  int                    stim_level = 0;
  int                    sent_count = 0;
  int                    burst_left = 1;

  always #5 clk = ~clk;

  binary_max_heap_queue_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  binary_max_heap_queue_checker heap_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tuser_i   (m_tuser),
    .mismatch_count_o (fail_count),
    .pending_o        (pending_count)
  );

  // Present one request, wait for its transfer, then maybe open a gap
  task automatic offer_request(input logic [OP_W-1:0] op, input key_t key, input addr_t pos);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - KEY_BITS - ADDR_W){1'b0}}, pos, key};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sent_count++;
    case (op)
      OP_INSERT:      if (stim_level < CAPACITY) stim_level++;
      OP_EXTRACT_MAX: if (stim_level > 0) stim_level--;
      OP_EXTRACT_AT:  if (int'(pos) < stim_level) stim_level--;
      default: ;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 35);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      6, 7, 8: return key_t'(int'($urandom_range(0, 16)) - 8);  // ties likely
      9: begin
        case ($urandom_range(0, 3))
          0:       return {1'b0, {(KEY_BITS-1){1'b1}}};
          1:       return {1'b1, {(KEY_BITS-1){1'b0}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return key_t'($urandom);
    endcase
  endfunction

  // Receiver: segments of open, random, sparse and long-held ready
  initial begin : rx_pattern
    rx_mode_e mode;
    int       seg;
    int       seg_len;
    seg = 0;
    forever begin
      if (seg == 4 || $urandom_range(0, 15) == 0) begin
        mode    = RX_HOLD;
        seg_len = $urandom_range(250, 400);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 2));
        seg_len = $urandom_range(10, 60);
      end
      repeat (seg_len) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= 1'b0;
        endcase
      end
      seg++;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    key_t        seed_keys [7];
    int          phase_kind;
    int          phase_len;
    int          roll;
    logic [OP_W-1:0] op;
    addr_t       pos;
    seed_keys = '{50, 10, 40, 5, 6, 35, 38};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-heap errors, unused op, both sift directions, extremes
    offer_request(OP_EXTRACT_MAX, key_t'($urandom), addr_t'($urandom));
    offer_request(OP_EXTRACT_AT, key_t'($urandom), '0);
    offer_request(OP_UNUSED, '1, '1);
    foreach (seed_keys[i]) offer_request(OP_INSERT, seed_keys[i], addr_t'($urandom));
    // last entry lands under a small parent and must climb
    offer_request(OP_EXTRACT_AT, key_t'($urandom), addr_t'(3));
    offer_request(OP_EXTRACT_AT, key_t'($urandom), addr_t'(5));  // last entry itself
    offer_request(OP_EXTRACT_AT, key_t'($urandom), addr_t'(5));  // now out of range
    offer_request(OP_EXTRACT_AT, key_t'($urandom), '1);
    offer_request(OP_INSERT, {1'b0, {(KEY_BITS-1){1'b1}}}, '1);
    offer_request(OP_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, '0);
    offer_request(OP_INSERT, '1, addr_t'($urandom));
    offer_request(OP_INSERT, '0, addr_t'($urandom));
    offer_request(OP_INSERT, key_t'(10), addr_t'($urandom));
    offer_request(OP_EXTRACT_AT, key_t'($urandom), '0);  // root, sifts down
    repeat (4) offer_request(OP_EXTRACT_MAX, key_t'($urandom), addr_t'($urandom));
    offer_request(OP_UNUSED, '0, '0);
    drain_results();

    // Random phases: grow (reaches full), shrink (reaches empty), mixed
    while (sent_count < REQUEST_TOTAL) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(40, 160);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) op = OP_UNUSED;
        else begin
          case (phase_kind)
            0:       op = (roll < 78) ? OP_INSERT : (roll < 89) ? OP_EXTRACT_MAX : OP_EXTRACT_AT;
            1:       op = (roll < 28) ? OP_INSERT : (roll < 64) ? OP_EXTRACT_MAX : OP_EXTRACT_AT;
            default: op = (roll < 50) ? OP_INSERT : (roll < 75) ? OP_EXTRACT_MAX : OP_EXTRACT_AT;
          endcase
        end
        if (op == OP_EXTRACT_AT && stim_level > 0 && $urandom_range(0, 4) != 0)
          pos = addr_t'($urandom_range(0, stim_level - 1));
        else
          pos = addr_t'($urandom_range(0, CAPACITY - 1));
        offer_request(op, pick_key(), pos);
      end
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[binary_max_heap_queue_top] OK");
    end else begin
      $display("[binary_max_heap_queue_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #50_000_000;
    $display("[binary_max_heap_queue_top] ERROR");
    $finish;
  end

endmodule
